// ===== design/sop_pkg.sv =====
// Package for the sky offset projection block: fixed constants, CORDIC arctangent table
// and the shared CORDIC stage type. Used by sop_cordic and sky_offset_projection.
package sop_pkg;

	localparam int unsigned ANGLE_W = 32;
	localparam int unsigned OFF_W   = 29;
	localparam int unsigned RAD_W   = 28;
	localparam int unsigned CW      = 34; // CORDIC datapath width (Q30 plus growth)

	localparam logic [27:0] OFF_LIMIT    = 28'd211215360;
	localparam logic [31:0] GAIN_Q30     = 32'd652032874;
	localparam logic [31:0] ARCSEC_SCALE = 32'd844860646;

	// RA: ms*2^32/86400000 ; Dec: mas*2^32/1296000000 (rounded half up)
	localparam logic [1:0] FMT_BINARY = 2'd0;

	localparam logic [1:0] REG_CENTER_RA    = 2'd0;
	localparam logic [1:0] REG_CENTER_DEC   = 2'd1;
	localparam logic [1:0] REG_INPUT_FORMAT = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic [1:0]           q;
	} cordic_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ===== design/sky_offset_projection.sv =====
// Top level of the sky offset projection: input conversion, three CORDICs, products,
// scaling and a pipelined integer square root. Depends on sop_pkg and sop_cordic.
//
// Usage:
//   Input channel in_valid/in_stall carries one catalog position per transaction,
//   either binary angles or sexagesimal fields as chosen by input_format.
//   Output channel out_valid/out_stall carries offset_east, offset_north,
//   radial_distance and last_out, one result per input item, in order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is always
//   high. Write registers only while the pipeline holds no items.
//   Throughput: one item per cycle while the chain is not frozen by out_stall. The
//   pipeline holds four input conversion stages, the CORDIC input register and one
//   stage per iteration (iterations capped at 32), six multiply/scale stages and 29
//   root stages, one per result bit.
//   The whole pipeline is one shift chain with valid bits; when out_stall is high
//   and the last stage holds a result the chain freezes, and in_stall follows, so
//   nothing is lost or repeated.
//   Reset clears the configuration registers and valid bits to zero and empties the pipeline.
module sky_offset_projection #(
	parameter int unsigned CORDIC_ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        ra_angle,
	input  logic signed [31:0] dec_angle,
	input  logic [4:0]         ra_hours,
	input  logic [5:0]         ra_minutes,
	input  logic [15:0]        ra_millisec,
	input  logic               dec_negative,
	input  logic [6:0]         dec_degrees,
	input  logic [5:0]         dec_arcmin,
	input  logic [15:0]        dec_milliarcsec,
	input  logic               last_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [28:0] offset_east,
	output logic signed [28:0] offset_north,
	output logic [27:0]        radial_distance,
	output logic               last_out
);

	localparam int unsigned NC  = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
	localparam int unsigned SQ  = 29;              // root bits, one per stage
	localparam int unsigned LAT = 4 + (NC + 1) + 6 + SQ;

	localparam logic [71:0] RA_DIV  = 72'd86400000;
	localparam logic [71:0] DEC_DIV = 72'd1296000000;

	logic [31:0] center_ra_q;
	logic [31:0] center_dec_q;
	logic        fmt_q;
	logic        en;
	logic [LAT-1:0] vld_q;
	logic [LAT-1:0] last_q;

	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_ra_q  <= '0;
			center_dec_q <= '0;
			fmt_q        <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sop_pkg::REG_CENTER_RA:    center_ra_q  <= cfg_data;
				sop_pkg::REG_CENTER_DEC:   center_dec_q <= cfg_data;
				sop_pkg::REG_INPUT_FORMAT: fmt_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;

	// Valid and batch mark travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	always_ff @(posedge clk) begin
		if (en) last_q <= {last_q[LAT-2:0], last_item};
	end

	// Stage 1: sexagesimal sums
	logic [31:0] ms_s1, mas_s1, rab_s1, decb_s1;
	logic        neg_s1, fmt_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ms_s1   <= 32'(ra_hours) * 32'd3600000 + 32'(ra_minutes) * 32'd60000
			           + 32'(ra_millisec);
			mas_s1  <= 32'(dec_degrees) * 32'd3600000 + 32'(dec_arcmin) * 32'd60000
			           + 32'(dec_milliarcsec);
			neg_s1  <= dec_negative;
			fmt_s1  <= fmt_q;
			rab_s1  <= ra_angle;
			decb_s1 <= dec_angle;
		end
	end

	// Stage 2: quotient estimate by constant reciprocal floor(2^64/D), never above
	// the true quotient and at most two below it; refined in stages 3 and 4.
	localparam logic [71:0] RA_REC  = (72'd1 << 64) / RA_DIV;
	localparam logic [71:0] DEC_REC = (72'd1 << 64) / DEC_DIV;
	logic [71:0] ran_s2, decn_s2;
	logic [35:0] raq_s2, decq_s2;
	logic [31:0] rab_s2, decb_s2;
	logic neg_s2, fmt_s2;
	always_ff @(posedge clk) begin
		logic [71:0] nr, nd;
		logic [71:0] pr, pd;
		nr = ({40'd0, ms_s1} << 32) + 72'd43200000;
		nd = ({40'd0, mas_s1} << 32) + 72'd648000000;
		pr = 72'(ms_s1) * RA_REC;
		pd = 72'(mas_s1) * DEC_REC;
		if (en) begin
			ran_s2  <= nr;
			decn_s2 <= nd;
			raq_s2  <= 36'(pr >> 32);
			decq_s2 <= 36'(pd >> 32);
			rab_s2  <= rab_s1;
			decb_s2 <= decb_s1;
			neg_s2  <= neg_s1;
			fmt_s2  <= fmt_s1;
		end
	end

	// Stage 3: remainder after estimate
	logic [71:0] rar_s3, decr_s3;
	logic [35:0] raq_s3, decq_s3;
	logic [31:0] rab_s3, decb_s3;
	logic neg_s3, fmt_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			rar_s3  <= ran_s2 - 72'(raq_s2) * RA_DIV;
			decr_s3 <= decn_s2 - 72'(decq_s2) * DEC_DIV;
			raq_s3  <= raq_s2;
			decq_s3 <= decq_s2;
			rab_s3  <= rab_s2;
			decb_s3 <= decb_s2;
			neg_s3  <= neg_s2;
			fmt_s3  <= fmt_s2;
		end
	end

	// Stage 4: correct quotient (estimate low by a few), select format, offset RA
	logic [31:0] ra_s4, dec_s4, cdec_s4;
	always_ff @(posedge clk) begin
		logic [35:0] qr, qd;
		logic [71:0] rr, rd;
		logic [31:0] ra, dec;
		qr = raq_s3; rr = rar_s3;
		qd = decq_s3; rd = decr_s3;
		for (int k = 0; k < 3; k++) begin
			if (rr >= RA_DIV)  begin rr = rr - RA_DIV;  qr = qr + 36'd1; end
			if (rd >= DEC_DIV) begin rd = rd - DEC_DIV; qd = qd + 36'd1; end
		end
		if (fmt_s3) begin
			ra  = qr[31:0];
			dec = neg_s3 ? (32'd0 - qd[31:0]) : qd[31:0];
		end else begin
			ra  = rab_s3;
			dec = decb_s3;
		end
		if (en) begin
			ra_s4   <= ra - center_ra_q;
			dec_s4  <= dec;
			cdec_s4 <= center_dec_q;
		end
	end

	// Three CORDICs in lock step
	logic signed [sop_pkg::CW-1:0] cda_c, sda_c, cd_c, sd_c, cd0_c, sd0_c;
	sop_cordic #(.ITER(NC)) u_cordic_ra  (.clk, .en, .angle(ra_s4),   .cos_o(cda_c), .sin_o(sda_c));
	sop_cordic #(.ITER(NC)) u_cordic_dec (.clk, .en, .angle(dec_s4),  .cos_o(cd_c),  .sin_o(sd_c));
	sop_cordic #(.ITER(NC)) u_cordic_cen (.clk, .en, .angle(cdec_s4), .cos_o(cd0_c), .sin_o(sd0_c));

	// Products stage A: l, t and sd*cd0 products
	logic signed [67:0] lp_a, tp_a, sdcd0_a;
	logic signed [sop_pkg::CW-1:0] cda_a;
	always_ff @(posedge clk) begin
		if (en) begin
			lp_a    <= 68'(cd_c) * 68'(sda_c);
			tp_a    <= 68'(cd_c) * 68'(sd0_c);
			sdcd0_a <= 68'(sd_c) * 68'(cd0_c);
			cda_a   <= cda_c;
		end
	end

	// Stage B: round l and t
	logic signed [37:0] l_b, t_b;
	logic signed [67:0] sdcd0_b;
	logic signed [sop_pkg::CW-1:0] cda_b;
	always_ff @(posedge clk) begin
		logic signed [67:0] lr, tr;
		lr = (lp_a + 68'sd536870912) >>> 30;
		tr = (tp_a + 68'sd536870912) >>> 30;
		if (en) begin
			l_b <= 38'(lr); t_b <= 38'(tr);
			sdcd0_b <= sdcd0_a; cda_b <= cda_a;
		end
	end

	logic signed [37:0] l_c;
	logic signed [67:0] m_c;
	always_ff @(posedge clk) begin
		if (en) begin
			l_c <= l_b;
			m_c <= sdcd0_b - 68'(t_b) * 68'(cda_b);
		end
	end

	// Stage D: round M, scale both
	logic signed [71:0] ep_d, np_d;
	always_ff @(posedge clk) begin
		logic signed [67:0] mr;
		mr = (m_c + 68'sd536870912) >>> 30;
		if (en) begin
			ep_d <= 72'(l_c) * 72'(signed'({1'b0, sop_pkg::ARCSEC_SCALE}));
			np_d <= 72'(38'(mr)) * 72'(signed'({1'b0, sop_pkg::ARCSEC_SCALE}));
		end
	end

	// Stage E: round and saturate offsets
	logic signed [28:0] e_e, n_e;
	function automatic logic signed [28:0] sat_off(input logic signed [71:0] p);
		logic signed [71:0] v;
		v = (p + 72'sd2147483648) >>> 32;
		if (v > $signed(72'(sop_pkg::OFF_LIMIT))) return 29'(sop_pkg::OFF_LIMIT);
		if (v < -$signed(72'(sop_pkg::OFF_LIMIT))) return -29'(sop_pkg::OFF_LIMIT);
		return 29'(v);
	endfunction
	always_ff @(posedge clk) begin
		if (en) begin
			e_e <= sat_off(ep_d);
			n_e <= sat_off(np_d);
		end
	end

	// Stage F: sum of squares, loaded into the head of the root chain
	logic [57:0] rem_q [0:SQ];
	logic [28:0] root_q [0:SQ];
	logic [56:0] val_q [0:SQ];
	logic signed [28:0] eo_q [0:SQ];
	logic signed [28:0] no_q [0:SQ];
	always_ff @(posedge clk) begin
		if (en) begin
			val_q[0]  <= 57'(e_e) * 57'(e_e) + 57'(n_e) * 57'(n_e);
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			eo_q[0]   <= e_e;
			no_q[0]   <= n_e;
		end
	end

	// Square root: one result bit per stage, restoring
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			logic [57:0] r2, trial;
			r2 = {rem_q[k][55:0], 2'(val_q[k] >> (2*(SQ-1-k)))};
			trial = 58'({root_q[k][27:0], 2'b01});
			if (en) begin
				if (r2 >= trial) begin
					rem_q[k+1]  <= r2 - trial;
					root_q[k+1] <= {root_q[k][27:0], 1'b1};
				end else begin
					rem_q[k+1]  <= r2;
					root_q[k+1] <= {root_q[k][27:0], 1'b0};
				end
				val_q[k+1] <= val_q[k];
				eo_q[k+1]  <= eo_q[k];
				no_q[k+1]  <= no_q[k];
			end
		end
	end

	// Output: round and saturate radius
	always_comb begin
		logic [28:0] r;
		r = root_q[SQ] + ((rem_q[SQ] > 58'(root_q[SQ])) ? 29'd1 : 29'd0);
		radial_distance = (r > 29'(sop_pkg::OFF_LIMIT)) ? sop_pkg::OFF_LIMIT : r[27:0];
		offset_east  = eo_q[SQ];
		offset_north = no_q[SQ];
		out_valid    = vld_q[LAT-1];
		last_out     = last_q[LAT-1];
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(offset_east))
		else $error("result changed under stall");
	a_install: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
	a_radius: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> radial_distance <= sop_pkg::OFF_LIMIT)
		else $error("radius above limit");

endmodule

// ===== design/sop_cordic.sv =====
// Pipelined rotation CORDIC: one stage per iteration, output Q30 cos and sin.
// Depends on sop_pkg. Advances only when en is high.
module sop_cordic #(
	parameter int unsigned ITER = 24
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [sop_pkg::ANGLE_W-1:0]    angle,
	output logic signed [sop_pkg::CW-1:0]  cos_o,
	output logic signed [sop_pkg::CW-1:0]  sin_o
);

	localparam int unsigned N = (ITER > 32) ? 32 : ITER;

	sop_pkg::cordic_t st [0:N];
	sop_pkg::cordic_t st0_c;

	// Reduce to nearest quadrant, residual in [-45, 45) degrees
	always_comb begin
		logic [31:0] qa;
		logic [31:0] d;
		qa = angle + 32'h20000000;
		d = angle - {qa[31:30], 30'd0};
		st0_c.q = qa[31:30];
		st0_c.z = sop_pkg::CW'(signed'(d));
		st0_c.x = sop_pkg::CW'(signed'({1'b0, sop_pkg::GAIN_Q30}));
		st0_c.y = '0;
	end

	always_ff @(posedge clk) begin
		if (en) st[0] <= st0_c;
	end

	// One micro-rotation per register stage
	for (genvar i = 0; i < N; i++) begin : g_iter
		sop_pkg::cordic_t nx_c;
		always_comb begin
			logic signed [sop_pkg::CW-1:0] a;
			a = sop_pkg::CW'(signed'({1'b0, sop_pkg::atan_entry(5'(i))}));
			nx_c.q = st[i].q;
			if (!st[i].z[sop_pkg::CW-1]) begin
				nx_c.x = st[i].x - (st[i].y >>> i);
				nx_c.y = st[i].y + (st[i].x >>> i);
				nx_c.z = st[i].z - a;
			end else begin
				nx_c.x = st[i].x + (st[i].y >>> i);
				nx_c.y = st[i].y - (st[i].x >>> i);
				nx_c.z = st[i].z + a;
			end
		end
		always_ff @(posedge clk) begin
			if (en) st[i+1] <= nx_c;
		end
	end

	// Apply quadrant by swap and negate
	always_comb begin
		case (st[N].q)
			2'd0: begin cos_o = st[N].x;  sin_o = st[N].y;  end
			2'd1: begin cos_o = -st[N].y; sin_o = st[N].x;  end
			2'd2: begin cos_o = -st[N].x; sin_o = -st[N].y; end
			default: begin cos_o = st[N].y; sin_o = -st[N].x; end
		endcase
	end

endmodule
